// ===== rtl/ppt_pkg.sv =====
package ppt_pkg;

  // Vertex field width and physical table depth
  localparam int VW          = 6;
  localparam int TABLE_DEPTH = 64;

  typedef logic [VW-1:0] vertex_t;

  // Item operation codes
  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_PATH   = 2'd2
  } mode_t;

  // Controller states, one-hot
  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_WALK     = 7'b0000010,
    S_FETCH    = 7'b0000100,
    S_EMIT_SRC = 7'b0001000,
    S_POP_RD   = 7'b0010000,
    S_POP      = 7'b0100000,
    S_BROKEN   = 7'b1000000
  } state_t;

  // Requests to the predecessor table
  typedef struct packed {
    logic    rec;
    logic    clr;
    vertex_t wr_addr;
    vertex_t wr_data;
    logic    rd_en;
    vertex_t rd_addr;
  } pred_req_t;

  // Requests to the reverse stack
  typedef struct packed {
    logic    we;
    vertex_t waddr;
    vertex_t wdata;
    logic    re;
    vertex_t raddr;
  } stk_req_t;

endpackage

// ===== rtl/ppt_pred_table.sv =====
module ppt_pred_table (
  input  logic               clk,
  input  logic               rst,
  input  ppt_pkg::pred_req_t req,
  input  ppt_pkg::vertex_t   look_addr,
  output logic               look_valid,
  output ppt_pkg::vertex_t   rd_data
);
  import ppt_pkg::*;

  vertex_t                mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_bits;

  // Store predecessor and read it back through a registered read port
  always_ff @(posedge clk) begin
    if (req.rec) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  // Mark entries valid on record, drop all on clear or reset
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid_bits <= '0;
    end else if (req.rec) begin
      valid_bits[req.wr_addr] <= 1'b1;
    end
  end

  assign look_valid = valid_bits[look_addr];

endmodule

// ===== rtl/ppt_stack.sv =====
module ppt_stack (
  input  logic              clk,
  input  ppt_pkg::stk_req_t req,
  output ppt_pkg::vertex_t  rd_data
);
  import ppt_pkg::*;

  vertex_t mem [TABLE_DEPTH];

  // Push on write, registered read for pop
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/predecessor_path_table.sv =====
// Predecessor table with shortest-path reconstruction.
// Input channel (in_valid / in_stall) carries mode, from_vertex, to_vertex.
// A record item stores from_vertex as the predecessor of to_vertex; a clear
// item drops every predecessor. Neither gives a result or holds the input.
// A path item walks predecessors from to_vertex back to from_vertex, pushing
// each vertex on a stack, then sends the path source first on the output
// channel (out_valid / out_stall) as vertex, last, unreachable.
// Each walk step pushes the current vertex on the stack in S_WALK and reads
// its predecessor from the table; S_FETCH takes the registered read data.
// Emit alternates S_POP_RD and S_POP; the registered stack memory read sets
// the emit pace. A missing predecessor, an out-of-range endpoint or a walk
// longer than VERTICES-1 steps gives one item with last and unreachable set.
// One item is worked on at a time; in_stall is high until it is finished.
// A full output register holds the controller while out_stall is high; the
// next input item is taken as soon as the last result sits in that register.
// Reset empties the table and the output register.
module predecessor_path_table #(
  parameter int VERTICES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            mode,
  input  ppt_pkg::vertex_t      from_vertex,
  input  ppt_pkg::vertex_t      to_vertex,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ppt_pkg::vertex_t      vertex,
  output logic                  last,
  output logic                  unreachable
);
  import ppt_pkg::*;

  localparam logic [VW:0] VLIM  = (VW+1)'(VERTICES);
  localparam logic [VW:0] LIMIT = (VW+1)'(VERTICES - 1);

  state_t    state, state_next;
  vertex_t   src, src_next;
  vertex_t   des, des_next;
  vertex_t   cur, cur_next;
  vertex_t   depth, depth_next;
  pred_req_t preq;
  stk_req_t  sreq;
  logic      look_valid;
  vertex_t   pred_rdata;
  vertex_t   stk_rdata;
  logic      accept;
  logic      out_free;
  logic      walk_bad;
  logic      load;
  vertex_t   ld_vertex;
  logic      ld_last;
  logic      ld_unr;

  ppt_pred_table u_pred (
    .clk       (clk),
    .rst       (rst),
    .req       (preq),
    .look_addr (cur),
    .look_valid(look_valid),
    .rd_data   (pred_rdata)
  );

  ppt_stack u_stack (
    .clk    (clk),
    .req    (sreq),
    .rd_data(stk_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign walk_bad = ({1'b0, cur} >= VLIM) || !look_valid || ({1'b0, depth} >= LIMIT);

  // Sequence the walk and the emit
  always_comb begin
    state_next = state;
    src_next   = src;
    des_next   = des;
    cur_next   = cur;
    depth_next = depth;
    preq       = '0;
    sreq       = '0;
    load       = 1'b0;
    ld_vertex  = src;
    ld_last    = 1'b0;
    ld_unr     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_RECORD: begin
              if ({1'b0, to_vertex} < VLIM) begin
                preq.rec     = 1'b1;
                preq.wr_addr = to_vertex;
                preq.wr_data = from_vertex;
              end
            end
            MODE_CLEAR: begin
              preq.clr = 1'b1;
            end
            MODE_PATH: begin
              src_next   = from_vertex;
              des_next   = to_vertex;
              cur_next   = to_vertex;
              depth_next = '0;
              if (({1'b0, from_vertex} >= VLIM) || ({1'b0, to_vertex} >= VLIM)) begin
                state_next = S_BROKEN;
              end else begin
                state_next = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (cur == src) begin
          state_next = S_EMIT_SRC;
        end else if (walk_bad) begin
          state_next = S_BROKEN;
        end else begin
          sreq.we      = 1'b1;
          sreq.waddr   = depth;
          sreq.wdata   = cur;
          depth_next   = depth + 1'b1;
          preq.rd_en   = 1'b1;
          preq.rd_addr = cur;
          state_next   = S_FETCH;
        end
      end
      S_FETCH: begin
        cur_next   = pred_rdata;
        state_next = S_WALK;
      end
      S_EMIT_SRC: begin
        if (out_free) begin
          load       = 1'b1;
          ld_vertex  = src;
          ld_last    = (depth == '0);
          state_next = (depth == '0) ? S_IDLE : S_POP_RD;
        end
      end
      S_POP_RD: begin
        sreq.re    = 1'b1;
        sreq.raddr = depth - 1'b1;
        depth_next = depth - 1'b1;
        state_next = S_POP;
      end
      S_POP: begin
        if (out_free) begin
          load       = 1'b1;
          ld_vertex  = stk_rdata;
          ld_last    = (depth == '0);
          state_next = (depth == '0) ? S_IDLE : S_POP_RD;
        end
      end
      S_BROKEN: begin
        if (out_free) begin
          load       = 1'b1;
          ld_vertex  = des;
          ld_last    = 1'b1;
          ld_unr     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      depth <= '0;
    end else begin
      state <= state_next;
      depth <= depth_next;
    end
    src <= src_next;
    des <= des_next;
    cur <= cur_next;
  end

  // Hold the result item until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      vertex      <= ld_vertex;
      last        <= ld_last;
      unreachable <= ld_unr;
    end
  end

  // Record and clear items do not hold the input
  a_short_items: assert property (@(posedge clk) disable iff (rst)
    accept && (mode != MODE_PATH) |=> !in_stall)
    else $error("record or clear item held the input");

  // Stack never grows past the walk limit
  a_depth_limit: assert property (@(posedge clk) disable iff (rst)
    {1'b0, depth} <= LIMIT)
    else $error("stack depth beyond limit");

  // A broken chain result always closes the run
  a_unr_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && unreachable |-> last)
    else $error("unreachable item without last");

  // Table read result is taken only right after a walk step
  a_fetch_order: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |-> $past(state) == S_WALK)
    else $error("fetch without walk step");

  // Output register is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !load)
    else $error("result item overwritten while stalled");

endmodule
